// ===== sv/tpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and codes of the two-phase commit voter
// Vote codes, send kinds, register indexes and the beat structs.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int VOTE_W   = 3;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 11;
  localparam int MSG_BALLOT_W = 32;

  localparam logic [VOTE_W-1:0] VOTE_NONE      = 3'd0;
  localparam logic [VOTE_W-1:0] VOTE_PROPOSE   = 3'd1;
  localparam logic [VOTE_W-1:0] VOTE_NAY       = 3'd2;
  localparam logic [VOTE_W-1:0] VOTE_YEA       = 3'd3;
  localparam logic [VOTE_W-1:0] VOTE_FINAL_NAY = 3'd5;
  localparam logic [VOTE_W-1:0] VOTE_FINAL_YEA = 3'd6;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BCAST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COORD = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 11'd1;

  localparam logic CFG_IS_COORD   = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  localparam logic ACT_PROPOSE = 1'b0;

  typedef struct packed {
    logic                    action;
    logic [VOTE_W-1:0]       msg_vote;
    logic [MSG_BALLOT_W-1:0] msg_ballot;
    logic                    check_ok;
  } in_beat_t;

  typedef struct packed {
    logic                    accepted;
    logic [KIND_W-1:0]       send_kind;
    logic [VOTE_W-1:0]       send_vote;
    logic [MSG_BALLOT_W-1:0] send_ballot;
    logic                    update_valid;
    logic                    update_commit;
  } out_beat_t;

endpackage

// ===== sv/tpc_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_stage: one valid/ready pipeline register
// Takes a beat whenever it is empty or its own beat leaves in the same cycle.
// ----------------------------------------------------------------------------
module tpc_stage #(
  parameter type T_DATA = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  T_DATA in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output T_DATA out_data
);

  logic  valid;
  T_DATA data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

// ===== sv/tpc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpc_core: vote state, ballot and reply counter of one node
// Works out the result of one beat and commits the state update on fire.
// ----------------------------------------------------------------------------
module tpc_core
  import tpc_pkg::*;
#(
  parameter int BALLOT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic              fire,
  input  in_beat_t          in_beat,
  output out_beat_t         res
);

  logic                   is_coord;
  logic [COUNT_W-1:0]     node_count;
  logic [VOTE_W-1:0]      vote_state, vote_state_next;
  logic [BALLOT_BITS-1:0] cur_ballot, cur_ballot_next;
  logic [COUNT_W-1:0]     reply_count, reply_count_next;

  logic [63:0]            mb_wide;
  logic [BALLOT_BITS-1:0] mb;
  logic [63:0]            mb_ext;
  logic [BALLOT_BITS-1:0] nb;
  logic [63:0]            nb_wide;
  logic [COUNT_W-1:0]     target;
  logic [COUNT_W-1:0]     rc_inc;
  logic [VOTE_W-1:0]      vs_mid;
  logic [VOTE_W-1:0]      decision;

  // message ballot taken modulo the ballot width
  assign mb_wide = {32'd0, in_beat.msg_ballot};
  assign mb      = mb_wide[BALLOT_BITS-1:0];
  assign mb_ext  = 64'(mb);
  // propose increment wraps at the ballot width
  assign nb      = cur_ballot + {{(BALLOT_BITS-1){1'b0}}, 1'b1};
  assign nb_wide = 64'(nb);
  assign target  = node_count - COUNT_ONE;

  always_comb begin
    res              = '0;
    vote_state_next  = vote_state;
    cur_ballot_next  = cur_ballot;
    reply_count_next = reply_count;
    rc_inc           = reply_count;
    vs_mid           = vote_state;
    decision         = VOTE_FINAL_NAY;

    if (in_beat.action == ACT_PROPOSE) begin
      if (node_count == COUNT_ONE) begin
        res.accepted      = 1'b1;
        res.update_valid  = 1'b1;
        res.update_commit = 1'b1;
      end else if (is_coord && vote_state == VOTE_NONE && in_beat.check_ok) begin
        reply_count_next = '0;
        cur_ballot_next  = nb;
        vote_state_next  = VOTE_PROPOSE;
        res.accepted     = 1'b1;
        res.send_kind    = KIND_BCAST;
        res.send_vote    = VOTE_PROPOSE;
        res.send_ballot  = nb_wide[MSG_BALLOT_W-1:0];
      end
    end else if (mb >= cur_ballot) begin
      cur_ballot_next = mb;
      if (is_coord) begin
        if ((in_beat.msg_vote == VOTE_YEA || in_beat.msg_vote == VOTE_NAY)
            && reply_count != COUNT_MAX) begin
          rc_inc = reply_count + COUNT_ONE;
        end
        reply_count_next = rc_inc;
        if (in_beat.msg_vote == VOTE_NAY && vote_state == VOTE_PROPOSE) begin
          vs_mid = VOTE_FINAL_NAY;
        end
        vote_state_next = vs_mid;
        if (rc_inc == target) begin
          if (vs_mid != VOTE_FINAL_NAY && in_beat.check_ok) begin
            decision = VOTE_FINAL_YEA;
          end
          res.send_kind     = KIND_BCAST;
          res.send_vote     = decision;
          res.send_ballot   = mb_ext[MSG_BALLOT_W-1:0];
          res.update_valid  = 1'b1;
          res.update_commit = (decision == VOTE_FINAL_YEA);
          vote_state_next   = VOTE_NONE;
        end
      end else begin
        if (in_beat.msg_vote == VOTE_PROPOSE && vote_state == VOTE_NONE) begin
          vote_state_next = in_beat.check_ok ? VOTE_YEA : VOTE_NAY;
          res.send_kind   = KIND_COORD;
          res.send_vote   = in_beat.check_ok ? VOTE_YEA : VOTE_NAY;
          res.send_ballot = mb_ext[MSG_BALLOT_W-1:0];
        end else if (in_beat.msg_vote == VOTE_FINAL_YEA ||
                     in_beat.msg_vote == VOTE_FINAL_NAY) begin
          res.update_valid  = 1'b1;
          res.update_commit = (in_beat.msg_vote == VOTE_FINAL_YEA);
          vote_state_next   = VOTE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_coord   <= 1'b0;
      node_count <= COUNT_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IS_COORD:   is_coord   <= cfg_wdata[0];
        CFG_NODE_COUNT: node_count <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_state  <= VOTE_NONE;
      cur_ballot  <= '0;
      reply_count <= '0;
    end else if (fire) begin
      vote_state  <= vote_state_next;
      cur_ballot  <= cur_ballot_next;
      reply_count <= reply_count_next;
    end
  end

  // a started vote leaves the coordinator proposing with a fresh count
  a_propose_starts: assert property (@(posedge clk) disable iff (rst)
    fire && res.send_kind == KIND_BCAST && res.send_vote == VOTE_PROPOSE
    |=> vote_state == VOTE_PROPOSE && reply_count == '0)
    else $error("propose did not start a vote");

  // no beat, no state change
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(vote_state) && $stable(cur_ballot) && $stable(reply_count))
    else $error("state moved without a beat");

  // a cohort reply records the vote it sent
  a_cohort_vote: assert property (@(posedge clk) disable iff (rst)
    fire && res.send_kind == KIND_COORD
    |=> vote_state == VOTE_YEA || vote_state == VOTE_NAY)
    else $error("cohort reply not recorded");

endmodule

// ===== sv/two_phase_commit_voter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_commit_voter_top: one node of a ballot-numbered two-phase commit
// Input register, combinational vote logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one beat per request: a local propose
//   request or a received ballot message. out_valid/out_ready/out_data carry
//   exactly one result beat per input beat, in order.
//   cfg_we/cfg_index/cfg_wdata write is_coordinator (index 0) and node_count
//   (index 1); write them only while no beat is in flight.
// Path: a beat goes from the input register through the vote logic into the
//   result register, and leaves from there.
// Throughput: one beat per cycle while out_ready holds high; the vote logic
//   between input and result register updates the node state in the same cycle.
// Reset (rst, synchronous): both registers empty, vote state unknown, ballot
//   and reply count zero, is_coordinator 0, node_count 1.
// Stall: when out_ready is low the result holds; the input register still
//   takes one more beat, then in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module two_phase_commit_voter_top
  import tpc_pkg::*;
#(
  parameter int BALLOT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data
);

  // input register -> vote logic
  logic      s1_valid;
  in_beat_t  s1_data;
  // vote logic -> result register
  logic      s2_ready;
  out_beat_t res;
  logic      fire;

  tpc_stage #(.T_DATA(in_beat_t)) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s2_ready),
    .out_data  (s1_data)
  );

  // a beat is processed when it moves into the result register
  assign fire = s1_valid && s2_ready;

  tpc_core #(.BALLOT_BITS(BALLOT_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_beat   (s1_data),
    .res       (res)
  );

  tpc_stage #(.T_DATA(out_beat_t)) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sim/tb_two_phase_commit_voter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_phase_commit_voter_top: self-checking bench for the commit voter
// Drives request beats through the valid/ready input, predicts every result
// beat with a behavioral model of the node, and compares each result beat
// field by field. Covers single-node commits, cohort and coordinator votes,
// ballot wrap, register extremes, stalls and random rounds.
// ----------------------------------------------------------------------------
module tb_two_phase_commit_voter_top;
  import tpc_pkg::*;

  // Action code for a received message (the package only names the propose)
  localparam logic ACT_MESSAGE = 1'b1;
  // Vote codes with no meaning; the block must still take over their ballot
  localparam logic [VOTE_W-1:0] VOTE_SPARE_4 = 3'd4;
  localparam logic [VOTE_W-1:0] VOTE_SPARE_7 = 3'd7;
  localparam logic [COUNT_W-1:0] NODES_BIG = 11'd1024;
  localparam int RANDOM_BEATS = 1800;
  localparam int MAX_GAP      = 10;
  localparam int LONG_HOLD    = 80;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic               cfg_index = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_beat_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_beat_t          out_data;

  // Predicted node state, kept in step with every accepted request beat
  logic                    pred_coord;
  logic [COUNT_W-1:0]      pred_nodes;
  logic [COUNT_W-1:0]      pred_replies;
  logic [VOTE_W-1:0]       pred_state;
  logic [MSG_BALLOT_W-1:0] pred_ballot;

  out_beat_t pending_results[$];   // expected result beats, oldest first
  int        sent_beats = 0;
  int        got_beats  = 0;
  int        mismatches = 0;
  bit        tx_idle    = 1'b1;    // sender inserts random gaps
  bit        rx_idle    = 1'b1;    // receiver inserts random stalls
  int        hold_len   = 0;       // one-shot long output stall, in cycles

  always #5 clk = ~clk;

  two_phase_commit_voter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Behavioral prediction of one request beat. Updates the predicted state
  // and returns the result beat the node must produce.
  // --------------------------------------------------------------------------
  function automatic out_beat_t predict_vote(input in_beat_t b);
    out_beat_t          r;
    logic [COUNT_W-1:0] target;
    logic [VOTE_W-1:0]  decision;
    r = '0;
    // Reply target wraps to all ones when node_count is zero
    target = pred_nodes - COUNT_ONE;
    if (b.action == ACT_PROPOSE) begin
      if (pred_nodes == COUNT_ONE) begin
        // Lone node: commit at once, whatever the role or state
        r.accepted      = 1'b1;
        r.update_valid  = 1'b1;
        r.update_commit = 1'b1;
      end else if (pred_coord && pred_state == VOTE_NONE && b.check_ok) begin
        pred_replies  = '0;
        pred_ballot   = pred_ballot + MSG_BALLOT_W'(1);   // wraps at the ballot width
        pred_state    = VOTE_PROPOSE;
        r.accepted    = 1'b1;
        r.send_kind   = KIND_BCAST;
        r.send_vote   = VOTE_PROPOSE;
        r.send_ballot = pred_ballot;
      end
    end else if (b.msg_ballot >= pred_ballot) begin
      // Stale ballots fall through with an empty result
      pred_ballot = b.msg_ballot;
      if (pred_coord) begin
        if ((b.msg_vote == VOTE_YEA || b.msg_vote == VOTE_NAY) &&
            pred_replies != COUNT_MAX) begin
          pred_replies = pred_replies + COUNT_ONE;
        end
        if (b.msg_vote == VOTE_NAY && pred_state == VOTE_PROPOSE) begin
          pred_state = VOTE_FINAL_NAY;
        end
        // The count is not cleared here, so a later current-ballot message that adds no reply decides again
        if (pred_replies == target) begin
          if (pred_state == VOTE_FINAL_NAY) decision = VOTE_FINAL_NAY;
          else decision = b.check_ok ? VOTE_FINAL_YEA : VOTE_FINAL_NAY;
          r.send_kind     = KIND_BCAST;
          r.send_vote     = decision;
          r.send_ballot   = b.msg_ballot;
          r.update_valid  = 1'b1;
          r.update_commit = (decision == VOTE_FINAL_YEA);
          pred_state      = VOTE_NONE;
        end
      end else begin
        if (b.msg_vote == VOTE_PROPOSE && pred_state == VOTE_NONE) begin
          pred_state    = b.check_ok ? VOTE_YEA : VOTE_NAY;
          r.send_kind   = KIND_COORD;
          r.send_vote   = pred_state;
          r.send_ballot = b.msg_ballot;
        end else if (b.msg_vote == VOTE_FINAL_YEA || b.msg_vote == VOTE_FINAL_NAY) begin
          r.update_valid  = 1'b1;
          r.update_commit = (b.msg_vote == VOTE_FINAL_YEA);
          pred_state      = VOTE_NONE;
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                got_beats, name, got, want));
    end
  endtask

  task automatic check_result(input out_beat_t got, input out_beat_t want);
    compare_field("accepted",      32'(got.accepted),      32'(want.accepted));
    compare_field("send_kind",     32'(got.send_kind),     32'(want.send_kind));
    compare_field("send_vote",     32'(got.send_vote),     32'(want.send_vote));
    compare_field("send_ballot",   got.send_ballot,        want.send_ballot);
    compare_field("update_valid",  32'(got.update_valid),  32'(want.update_valid));
    compare_field("update_commit", 32'(got.update_commit), 32'(want.update_commit));
  endtask

  // Result monitor: every accepted output beat is matched to the oldest
  // expectation. Requests are pushed at the edge where they are taken, which
  // always comes ahead of the edge where their result leaves.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_beats++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request waiting");
      end else begin
        check_result(out_data, pending_results.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall before each beat, plus the one-shot long hold.
  // Drives at the falling edge, one assignment per step.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      repeat (n) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one beat and returns at the edge where it is taken. valid is left
  // high so a back-to-back beat only changes the payload at the next step.
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_vote(b));
    sent_beats++;
  endtask

  task automatic send_propose(input logic check);
    in_beat_t b;
    b.action     = ACT_PROPOSE;
    b.msg_vote   = VOTE_W'($urandom_range(0, 7));   // ignored on a propose request
    b.msg_ballot = $urandom;
    b.check_ok   = check;
    send_beat(b);
  endtask

  task automatic send_msg(input logic [VOTE_W-1:0] vote,
                          input logic [MSG_BALLOT_W-1:0] ballot, input logic check);
    in_beat_t b;
    b.action     = ACT_MESSAGE;
    b.msg_vote   = vote;
    b.msg_ballot = ballot;
    b.check_ok   = check;
    send_beat(b);
  endtask

  // Drops valid and waits for every outstanding result, so the node is quiet before any register write.
  task automatic wait_results_done();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived",
                                pending_results.size()));
      pending_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IS_COORD) pred_coord = val[0];
    else pred_nodes = val;
  endtask

  // Idle the node, pull it back to the unknown state if a round left it
  // hanging (as a cohort, a final abort always does that), then set both regs.
  task automatic configure(input logic coord, input logic [COUNT_W-1:0] nodes);
    wait_results_done();
    if (pred_state != VOTE_NONE) begin
      write_reg(CFG_IS_COORD, COUNT_W'(1'b0));
      send_msg(VOTE_FINAL_NAY, pred_ballot, 1'b0);
      wait_results_done();
    end
    write_reg(CFG_IS_COORD, COUNT_W'(coord));
    write_reg(CFG_NODE_COUNT, nodes);
  endtask

  // --------------------------------------------------------------------------
  // Random round shapes
  // --------------------------------------------------------------------------
  // Coordinator: propose, then up to six replies at the current or next ballot,
  // sometimes one extra to hit the repeated decision.
  task automatic coord_round();
    int                 replies;
    logic [COUNT_W-1:0] target;
    if (pred_state != VOTE_NONE) configure(1'b1, pred_nodes);
    send_propose($urandom_range(0, 7) != 0);
    target  = pred_nodes - COUNT_ONE;
    replies = (target > 6) ? 6 : target;
    if ($urandom_range(0, 3) == 0) replies++;
    repeat (replies) begin
      send_msg(($urandom_range(0, 5) == 0) ? VOTE_NAY : VOTE_YEA,
               pred_ballot + $urandom_range(0, 1), $urandom_range(0, 5) != 0);
    end
  endtask

  // Cohort: PROPOSE, an occasional duplicate while busy, then the decision
  task automatic cohort_round();
    send_msg(VOTE_PROPOSE, pred_ballot + $urandom_range(0, 2), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 4) == 0) begin
      send_msg(VOTE_PROPOSE, pred_ballot, 1'($urandom_range(0, 1)));
    end
    send_msg($urandom_range(0, 1) ? VOTE_FINAL_YEA : VOTE_FINAL_NAY, pred_ballot,
             1'($urandom_range(0, 1)));
  endtask

  // Unstructured beats: any action and code, ballots stale, current, random or max
  task automatic noise_beats();
    in_beat_t b;
    int       k;
    repeat ($urandom_range(1, 3)) begin
      b.action   = 1'($urandom_range(0, 1));
      b.msg_vote = VOTE_W'($urandom_range(0, 7));
      k = $urandom_range(0, 9);
      if (k < 4) b.msg_ballot = $urandom;
      else if (k < 7) b.msg_ballot = pred_ballot;
      else if (k < 9) b.msg_ballot = pred_ballot - MSG_BALLOT_W'(1);
      else b.msg_ballot = '1;
      b.check_ok = 1'($urandom_range(0, 1));
      send_beat(b);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset config is cohort with one node: proposals commit at once
  task automatic test_single_node();
    send_propose(1'b1);
    send_propose(1'b0);
    send_msg(VOTE_PROPOSE, 32'd0, 1'b1);     // cohort still votes commit
    send_propose(1'b1);                       // lone node commits while voting
    send_msg(VOTE_FINAL_YEA, 32'd0, 1'b0);
    wait_results_done();
    write_reg(CFG_IS_COORD, COUNT_W'(1'b1));
    send_propose(1'b1);
    send_msg(VOTE_NONE, 32'd0, 1'b1);         // zero replies already meet target
  endtask

  task automatic test_cohort_votes();
    wait_results_done();
    write_reg(CFG_IS_COORD, COUNT_W'(1'b0));
    write_reg(CFG_NODE_COUNT, 11'd3);
    send_msg(VOTE_PROPOSE, 32'd5, 1'b1);
    send_msg(VOTE_PROPOSE, 32'd6, 1'b1);      // busy: only the ballot moves
    send_msg(VOTE_FINAL_YEA, 32'd6, 1'b0);
    send_msg(VOTE_PROPOSE, 32'd4, 1'b1);      // stale ballot
    send_msg(VOTE_PROPOSE, 32'd6, 1'b0);      // abort vote
    send_msg(VOTE_NONE, 32'd7, 1'b1);
    send_msg(VOTE_NAY, 32'd7, 1'b1);
    send_msg(VOTE_YEA, 32'd7, 1'b0);
    send_msg(VOTE_SPARE_4, 32'd7, 1'b1);
    send_msg(VOTE_SPARE_7, 32'd7, 1'b0);
    send_propose(1'b1);                       // cohort cannot start a vote
    send_msg(VOTE_FINAL_NAY, 32'hFFFF_FFFF, 1'b1);
  endtask

  // Coordinator with three nodes, starting from the maximum ballot
  task automatic test_coordinator_votes();
    wait_results_done();
    write_reg(CFG_IS_COORD, COUNT_W'(1'b1));
    send_propose(1'b0);                       // local check refuses
    send_propose(1'b1);                       // ballot wraps to zero
    send_propose(1'b1);                       // vote already running
    send_msg(VOTE_YEA, 32'd0, 1'b1);
    send_msg(VOTE_NAY, 32'd0, 1'b1);          // last reply, abort wins
    send_msg(VOTE_SPARE_7, 32'd0, 1'b1);      // count still at target: decides again
    send_propose(1'b1);
    send_msg(VOTE_YEA, 32'd0, 1'b1);          // stale reply
    send_msg(VOTE_YEA, 32'd1, 1'b1);
    send_msg(VOTE_YEA, 32'd1, 1'b0);          // own check turns it to abort
    send_propose(1'b1);
    send_msg(VOTE_NAY, 32'd2, 1'b1);
    send_msg(VOTE_YEA, 32'd3, 1'b1);          // newer ballot, remembered abort
  endtask

  task automatic test_register_extremes();
    configure(1'b1, NODES_BIG);
    send_propose(1'b1);
    repeat (3) send_msg(VOTE_YEA, pred_ballot, 1'b1);
    configure(1'b1, COUNT_MAX);
    send_propose(1'b1);
    repeat (2) send_msg(VOTE_NAY, pred_ballot, 1'b1);
  endtask

  // Long output hold while beats keep coming back to back; then the sender
  // stops until every result is home.
  task automatic test_backpressure();
    configure(1'b0, 11'd4);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_len = LONG_HOLD;
    repeat (10) cohort_round();
    wait_results_done();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_rounds();
    int                 goal;
    int                 k;
    logic               coord;
    logic [COUNT_W-1:0] nodes;
    goal = sent_beats + RANDOM_BEATS;
    while (sent_beats < goal) begin
      coord = 1'($urandom_range(0, 1));
      k = $urandom_range(0, 15);
      case (k)
        0:       nodes = '0;
        1:       nodes = COUNT_ONE;
        2:       nodes = NODES_BIG;
        3:       nodes = COUNT_MAX;
        default: nodes = COUNT_W'($urandom_range(2, 6));
      endcase
      configure(coord, nodes);
      // Mostly idling on both sides, now and then full rate
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      repeat (8) begin
        k = $urandom_range(0, 9);
        if (k >= 7) noise_beats();
        else if (coord) coord_round();
        else cohort_round();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pred_coord   = 1'b0;
    pred_nodes   = COUNT_ONE;
    pred_replies = '0;
    pred_state   = VOTE_NONE;
    pred_ballot  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_node();
    test_cohort_votes();
    test_coordinator_votes();
    test_register_extremes();
    test_backpressure();
    test_random_rounds();

    wait_results_done();
    repeat (10) @(posedge clk);
    $display("Covered %0d request beats and %0d result beats: cohort and coordinator votes,",
             sent_beats, got_beats);
    $display("node counts 0 to 2047, ballot wrap, repeated decisions and a long output stall.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule
